[hdl/assert_macros.svh]
// Assertion macros shared by the packet deframer RTL.
// Defining NO_ASSERTIONS removes every check and leaves empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge, held off during reset.
`define DPD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deframer assertion failed");
// Check that a condition never holds on a rising clock edge outside reset.
`define DPD_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("deframer forbidden condition seen");
`else
`define DPD_ASSERT(lbl, prop)
`define DPD_NEVER(lbl, cond)
`endif
`endif

[hdl/dpd_pkg.sv]
// Types, character codes and the hex digit decoder for the packet deframer.
// No dependencies; used by dpd_core and debug_packet_deframer.
package dpd_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PAYLOAD = 3'd1,
        PH_CK_HIGH = 3'd2,
        PH_CK_LOW  = 3'd3,
        PH_DISCARD = 3'd4
    } phase_t;

    // Reported events
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_RETRY    = 3'd1,
        EV_OVERFLOW = 3'd2,
        EV_CKERR    = 3'd3,
        EV_READY    = 3'd4
    } event_t;

    // Framing characters
    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_NAK   = 8'h2d;  // '-'

    // Hex digit ranges
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;
    localparam logic [7:0] CH_LOWA  = 8'h61;
    localparam logic [7:0] CH_LOWF  = 8'h66;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPF   = 8'h46;

    // One result transaction
    typedef struct packed {
        event_t      event_res;
        logic        stored;
        logic [7:0]  payload_index;
        logic [7:0]  payload_byte;
        logic [8:0]  payload_length;
    } result_t;

    // Decoded hex digit
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= CH_DIG0 && c <= CH_DIG9)
        begin
            h.val = 4'(c - CH_DIG0);
        end
        else if (c >= CH_LOWA && c <= CH_LOWF)
        begin
            h.val = 4'(c - CH_LOWA + 8'd10);
        end
        else if (c >= CH_UPA && c <= CH_UPF)
        begin
            h.val = 4'(c - CH_UPA + 8'd10);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

[hdl/debug_packet_deframer.sv]
// Top level of the packet deframer: handshake and result register.
// Depends on dpd_pkg, dpd_core and assert_macros.svh.
//
// Takes one received byte per transaction and returns exactly one result per
// byte, in the clock after it is accepted. A byte can be accepted in every clock
// cycle: the parser state updates in the cycle of acceptance and the result
// sits in a one-entry output register. in_stall rises only while that
// register holds a result and out_stall is high; a result taken in the same
// cycle frees room for the next byte at once. Payload bytes are echoed with
// their index; the block keeps no copy of the payload.
`include "assert_macros.svh"
module debug_packet_deframer #(
    parameter int CAPACITY = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic        stored,
    output logic [7:0]  payload_index,
    output logic [7:0]  payload_byte,
    output logic [8:0]  payload_length
);
    import dpd_pkg::*;

    logic     advance;
    logic     out_valid_reg, out_valid_next;
    result_t  res_calc;
    result_t  res_reg;

    // Accept while the result register is empty or draining
    assign in_stall = out_valid_reg && out_stall;
    assign advance  = in_valid && !in_stall;

    dpd_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (rx_byte),
        .res     (res_calc)
    );

    // Hold the result until taken
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_calc;
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = res_reg.event_res;
    assign stored         = res_reg.stored;
    assign payload_index  = res_reg.payload_index;
    assign payload_byte   = res_reg.payload_byte;
    assign payload_length = res_reg.payload_length;

    `DPD_ASSERT(a_accept_gives_result, advance |=> out_valid_reg)
    `DPD_ASSERT(a_stall_holds_result,
        out_valid_reg && out_stall |=> out_valid_reg && $stable(res_reg))
    `DPD_NEVER(a_no_accept_when_full, advance && out_valid_reg && out_stall)

endmodule

[hdl/dpd_core.sv]
// Parser state machine of the packet deframer: phase, count and checksums.
// Depends on dpd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dpd_core #(
    parameter int CAPACITY = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        rx_byte,
    output dpd_pkg::result_t  res
);
    import dpd_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > 9) ? CNT_W : 9;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         sum_reg, sum_next;
    logic [3:0]         ck_hi_reg, ck_hi_next;
    logic               ovf_reg, ovf_next;
    hex_t               digit;
    logic [EXT_W-1:0]   idx_ext, len_ext;

    assign digit = hex_decode(rx_byte);

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        ck_hi_next = ck_hi_reg;
        ovf_next   = ovf_reg;
        if (rx_byte == CH_START)
        begin
            phase_next = PH_PAYLOAD;
            count_next = '0;
            sum_next   = '0;
            ck_hi_next = '0;
            ovf_next   = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_PAYLOAD:
                begin
                    if (rx_byte == CH_HASH)
                    begin
                        phase_next = PH_CK_HIGH;
                    end
                    else if (count_reg >= CAP_CNT)
                    begin
                        phase_next = PH_DISCARD;
                        ovf_next   = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + rx_byte;
                    end
                end
                PH_CK_HIGH:
                begin
                    if (digit.ok)
                    begin
                        ck_hi_next = digit.val;
                        phase_next = PH_CK_LOW;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_CK_LOW:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Widen counts so the low bits can be taken at any capacity
    assign idx_ext = EXT_W'(count_reg);
    assign len_ext = EXT_W'(count_next);

    // Outputs
    always_comb
    begin
        res.event_res      = EV_NONE;
        res.stored         = 1'b0;
        res.payload_index  = 8'd0;
        res.payload_byte   = 8'd0;
        res.payload_length = len_ext[8:0];
        if (rx_byte != CH_START)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == CH_NAK)
                        res.event_res = EV_RETRY;
                end
                PH_PAYLOAD:
                begin
                    if (rx_byte != CH_HASH)
                    begin
                        if (count_reg >= CAP_CNT)
                        begin
                            res.event_res = EV_OVERFLOW;
                        end
                        else
                        begin
                            res.stored        = 1'b1;
                            res.payload_index = idx_ext[7:0];
                            res.payload_byte  = rx_byte;
                        end
                    end
                end
                PH_CK_HIGH:
                begin
                    if (!digit.ok)
                        res.event_res = EV_CKERR;
                end
                PH_CK_LOW:
                begin
                    if (digit.ok && {ck_hi_reg, digit.val} == sum_reg)
                        res.event_res = EV_READY;
                    else
                        res.event_res = EV_CKERR;
                end
                default:
                begin
                    res.event_res = EV_NONE;
                end
            endcase
        end
    end

    // Advance the parser on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
            ck_hi_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ck_hi_reg <= ck_hi_next;
            ovf_reg   <= ovf_next;
        end
    end

    `DPD_ASSERT(a_count_bound, count_reg <= CAP_CNT)
    `DPD_ASSERT(a_ovf_discard, ovf_reg == (phase_reg == PH_DISCARD))
    `DPD_ASSERT(a_stored_payload, advance && res.stored |-> phase_reg == PH_PAYLOAD)
    `DPD_ASSERT(a_start_clears,
        advance && rx_byte == CH_START |=> phase_reg == PH_PAYLOAD && count_reg == '0)
    `DPD_ASSERT(a_ready_idle,
        advance && res.event_res == EV_READY |=> phase_reg == PH_IDLE)

endmodule

[verif/debug_packet_deframer_tb.sv]
// Testbench for debug_packet_deframer: directed byte table, then random framed traffic.
// Depends on dpd_pkg and the deframer RTL; results are scored against an in-bench parser model.
module debug_packet_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dpd_pkg::*;

    localparam int CAP          = 256;
    localparam int TOTAL_ITEMS  = 650;
    localparam int HOLD_CYCLES  = 120;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_DIRECTED = 26;

    // Hex digit and non-hex characters used in the directed rows
    localparam logic [7:0] CH_TWO  = 8'h32;  // '2'
    localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CH_FOUR = 8'h34;  // '4'
    localparam logic [7:0] CH_LC_C = 8'h63;  // 'c'
    localparam logic [7:0] CH_LC_G = 8'h67;  // 'g'
    localparam logic [7:0] CH_UC_A = 8'h41;  // 'A'
    localparam logic [7:0] CH_UC_F = 8'h46;  // 'F'
    localparam logic [7:0] CH_UC_Z = 8'h5a;  // 'Z'

    typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_HIGH, FR_BAD_LOW, FR_CUT} frame_kind_t;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        result_t    want;
    } stim_row_t;

    localparam result_t NO_WANT = '0;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] event_res;
    logic       stored;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;
    logic [8:0] payload_length;

    // Parser model state
    phase_t     model_phase;
    int         model_count;
    logic [7:0] model_sum;
    logic [7:0] model_rcv;
    logic       model_ovf;

    result_t    expected_q[$];
    int         mismatches;
    int         results_seen;
    int         bytes_sent;
    int         cycles;
    int         n_ready;
    int         n_ckerr;
    int         n_ovf;
    int         n_retry;
    int         send_mode;
    int         mode_left;
    bit         pressure_go;

    // Directed rows: idle bytes, a short frame, empty frame, bad digits, restarts
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{CH_NAK,  1'b1, '{EV_RETRY, 1'b0, 8'h00, 8'h00, 9'd0}},
        '{8'h00,   1'b1, '{EV_NONE,  1'b0, 8'h00, 8'h00, 9'd0}},
        '{8'hff,   1'b1, '{EV_NONE,  1'b0, 8'h00, 8'h00, 9'd0}},
        '{CH_START, 1'b1, '{EV_NONE, 1'b0, 8'h00, 8'h00, 9'd0}},
        '{8'h00,   1'b1, '{EV_NONE,  1'b1, 8'h00, 8'h00, 9'd1}},
        '{8'hff,   1'b1, '{EV_NONE,  1'b1, 8'h01, 8'hff, 9'd2}},
        '{CH_NAK,  1'b0, NO_WANT},
        '{CH_HASH, 1'b0, NO_WANT},
        '{CH_TWO,  1'b0, NO_WANT},
        '{CH_LC_C, 1'b0, NO_WANT},
        '{CH_START, 1'b1, '{EV_NONE, 1'b0, 8'h00, 8'h00, 9'd0}},
        '{CH_HASH, 1'b0, NO_WANT},
        '{CH_ZERO, 1'b0, NO_WANT},
        '{CH_ZERO, 1'b1, '{EV_READY, 1'b0, 8'h00, 8'h00, 9'd0}},
        '{CH_START, 1'b0, NO_WANT},
        '{CH_UC_A, 1'b0, NO_WANT},
        '{CH_HASH, 1'b0, NO_WANT},
        '{CH_UC_Z, 1'b1, '{EV_CKERR, 1'b0, 8'h00, 8'h00, 9'd1}},
        '{CH_START, 1'b0, NO_WANT},
        '{CH_UC_F, 1'b0, NO_WANT},
        '{CH_HASH, 1'b0, NO_WANT},
        '{CH_FOUR, 1'b0, NO_WANT},
        '{CH_START, 1'b1, '{EV_NONE, 1'b0, 8'h00, 8'h00, 9'd0}},
        '{CH_HASH, 1'b0, NO_WANT},
        '{CH_ZERO, 1'b0, NO_WANT},
        '{CH_LC_G, 1'b1, '{EV_CKERR, 1'b0, 8'h00, 8'h00, 9'd0}}
    };

    debug_packet_deframer #(
        .CAPACITY(CAP)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .stored        (stored),
        .payload_index (payload_index),
        .payload_byte  (payload_byte),
        .payload_length(payload_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Decode one hex character; ok drops for anything outside 0-9, a-f, A-F
    function automatic logic [3:0] hex_value(input logic [7:0] c, output logic ok);
        ok = 1'b1;
        if (c >= CH_DIG0 && c <= CH_DIG9)
            return 4'(c - CH_DIG0);
        if (c >= CH_LOWA && c <= CH_LOWF)
            return 4'(c - CH_LOWA + 8'd10);
        if (c >= CH_UPA && c <= CH_UPF)
            return 4'(c - CH_UPA + 8'd10);
        ok = 1'b0;
        return 4'd0;
    endfunction

    // Advance the parser model by one byte and return the result it produces
    function automatic result_t deframe_step(input logic [7:0] b);
        result_t    r;
        logic       ok;
        logic [3:0] nib;
        r = '0;
        r.event_res = EV_NONE;
        if (b == CH_START)
        begin
            model_count = 0;
            model_sum   = 8'h00;
            model_rcv   = 8'h00;
            model_ovf   = 1'b0;
            model_phase = PH_PAYLOAD;
        end
        else
        begin
            case (model_phase)
                PH_IDLE:
                begin
                    if (b == CH_NAK)
                        r.event_res = EV_RETRY;
                end
                PH_PAYLOAD:
                begin
                    if (b == CH_HASH)
                        model_phase = PH_CK_HIGH;
                    else if (model_count >= CAP)
                    begin
                        model_ovf   = 1'b1;
                        model_phase = PH_DISCARD;
                        r.event_res = EV_OVERFLOW;
                    end
                    else
                    begin
                        r.stored        = 1'b1;
                        r.payload_index = model_count[7:0];
                        r.payload_byte  = b;
                        model_count     = model_count + 1;
                        model_sum       = model_sum + b;
                    end
                end
                PH_CK_HIGH:
                begin
                    nib = hex_value(b, ok);
                    if (!ok)
                    begin
                        model_phase = PH_IDLE;
                        r.event_res = EV_CKERR;
                    end
                    else
                    begin
                        model_rcv   = {nib, 4'h0};
                        model_phase = PH_CK_LOW;
                    end
                end
                PH_CK_LOW:
                begin
                    nib = hex_value(b, ok);
                    model_phase = PH_IDLE;
                    if (!ok)
                        r.event_res = EV_CKERR;
                    else
                    begin
                        model_rcv[3:0] = nib;
                        r.event_res = (model_rcv == model_sum) ? EV_READY : EV_CKERR;
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.payload_length = model_count[8:0];
        return r;
    endfunction

    // Hex character for a nibble, letters in random case
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return CH_DIG0 + 8'(nib);
        return (($urandom_range(0, 1) == 1) ? CH_UPA : CH_LOWA) + 8'(nib) - 8'd10;
    endfunction

    // Random byte that is not a hex digit and does not restart a packet
    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic       ok;
        logic [3:0] unused_nib;
        do
        begin
            c = 8'($urandom_range(0, 255));
            unused_nib = hex_value(c, ok);
        end
        while (ok || c == CH_START);
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] result %0d: %s got %0d, want %0d",
                     $realtime, results_seen, what, got, want);
    endtask

    // Offer one byte at the falling edge, hold it until accepted, then log its expectation
    task automatic send_item(input logic [7:0] b, input bit typed = 1'b0,
                             input result_t want = '0);
        int      gap;
        result_t pred;
        if (mode_left == 0)
        begin
            send_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        gap = 0;
        case (send_mode)
            1: if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
            2: if ($urandom_range(0, 14) == 0) gap = $urandom_range(8, 30);
            default: gap = 0;
        endcase
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = deframe_step(b);
        expected_q.push_back(typed ? want : pred);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Send one framed packet; the kind selects how its tail is damaged
    task automatic send_frame(input int len, input frame_kind_t kind);
        logic [7:0] b;
        logic [7:0] sum;
        int         cut_at;
        sum    = 8'h00;
        cut_at = (kind == FR_CUT && len > 0) ? $urandom_range(0, len - 1) : -1;
        send_item(CH_START);
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_START || b == CH_HASH)
                b ^= 8'h80;
            sum += b;
            send_item(b);
            if (i == cut_at)
                return;
        end
        send_item(CH_HASH);
        if (kind == FR_BAD_SUM)
            sum ^= 8'(1 << $urandom_range(0, 7));
        send_item((kind == FR_BAD_HIGH) ? non_hex_char() : hex_char(sum[7:4]));
        send_item((kind == FR_BAD_LOW) ? non_hex_char() : hex_char(sum[3:0]));
    endtask

    // Score every accepted result against the oldest expectation
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
                report_mismatch("unexpected result, event", int'(event_res), -1);
            else
            begin
                want = expected_q.pop_front();
                if (event_res !== want.event_res)
                    report_mismatch("event_res", int'(event_res), int'(want.event_res));
                if (stored !== want.stored)
                    report_mismatch("stored", int'(stored), int'(want.stored));
                if (payload_index !== want.payload_index)
                    report_mismatch("payload_index", int'(payload_index),
                                    int'(want.payload_index));
                if (payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", int'(payload_byte),
                                    int'(want.payload_byte));
                if (payload_length !== want.payload_length)
                    report_mismatch("payload_length", int'(payload_length),
                                    int'(want.payload_length));
                case (want.event_res)
                    EV_READY:    n_ready++;
                    EV_CKERR:    n_ckerr++;
                    EV_OVERFLOW: n_ovf++;
                    EV_RETRY:    n_retry++;
                    default:     ;
                endcase
            end
        end
    end

    // Drive out_stall: quiet stretches, light stalls, long stalls, and one long hold
    initial
    begin : receiver
        int  mode;
        int  span;
        int  stall_run;
        int  hold_cnt;
        bit  held;
        out_stall = 1'b0;
        held      = 1'b0;
        stall_run = 0;
        @(posedge rst_n);
        forever
        begin
            if (pressure_go && !held)
            begin
                held = 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 80);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2:
                    begin
                        if (stall_run == 0 && $urandom_range(0, 15) == 0)
                            stall_run = $urandom_range(8, 30);
                        out_stall <= (stall_run > 0);
                        if (stall_run > 0)
                            stall_run--;
                    end
                    default: out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Stop a hung run
    initial
    begin : watchdog
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int          frame_no;
        int          pick;
        int          len;
        frame_kind_t kind;
        in_valid       = 1'b0;
        rx_byte        = 8'h00;
        rst_n          = 1'b0;
        pressure_go    = 1'b0;
        mismatches     = 0;
        results_seen   = 0;
        bytes_sent     = 0;
        n_ready        = 0;
        n_ckerr        = 0;
        n_ovf          = 0;
        n_retry        = 0;
        send_mode      = 0;
        mode_left      = 0;
        model_phase    = PH_IDLE;
        model_count    = 0;
        model_sum      = 8'h00;
        model_rcv      = 8'h00;
        model_ovf      = 1'b0;
        frame_no       = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_item(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].want);

        // Random framed traffic, with a full-capacity and an overflowing frame early on
        pressure_go = 1'b1;
        while (bytes_sent < TOTAL_ITEMS)
        begin
            frame_no++;
            if (frame_no == 3)
                send_frame(CAP, FR_GOOD);
            else if (frame_no == 6)
            begin
                send_frame(CAP + 4, FR_GOOD);
                repeat (3) send_item(CH_NAK);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 12);
                if (pick < 8)
                begin
                    repeat ($urandom_range(1, 5))
                        send_item(($urandom_range(0, 2) == 0) ? CH_NAK
                                                              : 8'($urandom_range(0, 255)));
                end
                else
                begin
                    if (pick < 65)
                        kind = FR_GOOD;
                    else if (pick < 77)
                        kind = FR_BAD_SUM;
                    else if (pick < 85)
                        kind = FR_BAD_HIGH;
                    else if (pick < 93)
                        kind = FR_BAD_LOW;
                    else
                        kind = FR_CUT;
                    send_frame(len, kind);
                end
            end
        end
        in_valid <= 1'b0;

        // Drain, then give the output register time to show any stray result
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Run covered %0d bytes in %0d frames plus directed cases.",
                 bytes_sent, frame_no);
        $display("Events seen: %0d ready, %0d checksum errors, %0d overflows, %0d retries.",
                 n_ready, n_ckerr, n_ovf, n_retry);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
